[sv/glt_pkg.sv]
// Shared types, constants and helpers for the ID lifetime table.
// No dependencies; imported by glt_cell and graph_id_lifetime_table.
package glt_pkg;

    localparam int ENTRIES   = 32;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int ID_W      = 32;
    localparam int CYC_W     = 32;
    localparam int OUT_CNT_W = 6;

    localparam logic [CYC_W-1:0] AGE_LIMIT_RESET = 32'd100;

    // slot codes
    localparam logic [1:0] ST_UNINIT  = 2'd0;
    localparam logic [1:0] ST_CLEARED = 2'd1;
    localparam logic [1:0] ST_SEEN    = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_START  = 2'd1,
        OP_CHECK  = 2'd2,
        OP_END    = 2'd3
    } glt_op_t;

    typedef enum logic [1:0] {
        GLT_IDLE,
        GLT_BUSY,
        GLT_DRAIN
    } glt_state_t;

    // token walking the cell row
    typedef struct packed {
        logic             active;
        glt_op_t          op;
        logic [ID_W-1:0]  id;
        logic [CYC_W-1:0] cyc;
        logic             found;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic [CNT_W-1:0] removed;
        logic [CNT_W-1:0] count;
    } glt_tok_t;

    // new-entry write broadcast to the row
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [ID_W-1:0]  key;
        logic [CYC_W-1:0] birth;
    } glt_wr_t;

    // slot 0 in bits 1:0, slot 1 in bits 3:2
    function automatic logic [3:0] set_slot(input logic [3:0] slots, input logic sel,
                                            input logic [1:0] code);
        logic [3:0] r;
        r = slots;
        if (sel)
        begin
            r[3:2] = code;
        end
        else
        begin
            r[1:0] = code;
        end
        return r;
    endfunction

endpackage

[sv/glt_cell.sv]
// One table entry: key, slot states, seen flag and birth cycle.
// Processes the passing token and registers it toward the next cell. Uses glt_pkg.
module glt_cell import glt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] idx,
    input  glt_tok_t         tok_in,
    input  glt_wr_t          wr,
    input  logic [CYC_W-1:0] latest_cycle,
    input  logic [CYC_W-1:0] age_limit,
    output glt_tok_t         tok_out
);

    logic             valid_reg, valid_next;
    logic [ID_W-1:0]  key_reg, key_next;
    logic [3:0]       slot_reg, slot_next;
    logic             seen_reg, seen_next;
    logic [CYC_W-1:0] birth_reg, birth_next;
    glt_tok_t         tok_reg, tok_next;

    logic             match;
    logic             both_clr;
    logic [CYC_W-1:0] age;

    assign match    = valid_reg && (key_reg == tok_in.id);
    assign both_clr = (slot_reg[1:0] == ST_CLEARED) && (slot_reg[3:2] == ST_CLEARED);
    assign age      = latest_cycle - birth_reg;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        slot_next  = slot_reg;
        seen_next  = seen_reg;
        birth_next = birth_reg;
        tok_next   = tok_in;

        if (wr.en && (wr.idx == idx))
        begin
            valid_next = 1'b1;
            key_next   = wr.key;
            slot_next  = {ST_UNINIT, ST_UNINIT};
            seen_next  = 1'b0;
            birth_next = wr.birth;
        end

        if (tok_in.active)
        begin
            case (tok_in.op)
                OP_INSERT:
                begin
                    if (match)
                    begin
                        tok_next.found = 1'b1;
                    end
                    if (!valid_reg && !tok_in.free_found)
                    begin
                        tok_next.free_found = 1'b1;
                        tok_next.free_idx   = idx;
                    end
                end
                OP_START:
                begin
                    if (valid_reg)
                    begin
                        slot_next = set_slot(slot_reg, tok_in.cyc[0], ST_CLEARED);
                    end
                end
                OP_CHECK:
                begin
                    if (match)
                    begin
                        slot_next      = set_slot(slot_reg, tok_in.cyc[0], ST_SEEN);
                        seen_next      = 1'b1;
                        tok_next.found = 1'b1;
                    end
                end
                OP_END:
                begin
                    if (valid_reg && both_clr && (seen_reg || (age > age_limit)))
                    begin
                        valid_next       = 1'b0;
                        tok_next.removed = tok_in.removed + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
            tok_next.count = tok_in.count + CNT_W'(valid_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        slot_reg  <= slot_next;
        seen_reg  <= seen_next;
        birth_reg <= birth_next;
    end

    assign tok_out = tok_reg;

endmodule

[sv/graph_id_lifetime_table.sv]
// An accepted beat is registered as a token, walks the cell row one cell per cycle, then passes
// the result stage, where the insert commit is written, and the output register. One beat at a
// time: a new beat is taken only after the last result has been loaded into the output register.
// Reset (rst_n, async low) clears all valid bits, latest cycle, and sets age_limit to 100.
// No clearing pass: the block takes a beat in the first cycle after reset.
module graph_id_lifetime_table import glt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration: age_limit
    input  logic                 cfg_we,
    input  logic [CYC_W-1:0]     cfg_wdata,
    // input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           op,
    input  logic [ID_W-1:0]      graph_id,
    input  logic [CYC_W-1:0]     cycle,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit,
    output logic                 inserted,
    output logic                 table_full,
    output logic [OUT_CNT_W-1:0] removed_count,
    output logic [OUT_CNT_W-1:0] entry_count
);

    glt_state_t state_reg, state_next;

    logic [CYC_W-1:0] age_limit_reg;
    logic [CYC_W-1:0] latest_cycle_reg;

    // token injected into cell 0
    glt_tok_t tok_in_reg, tok_in_next;
    glt_tok_t chain [ENTRIES+1];
    glt_tok_t tok_last;
    glt_wr_t  wr;

    logic accept;
    logic res_load;
    logic out_load;

    // result holding stage between row exit and output register
    logic                 res_hit_reg, res_ins_reg, res_full_reg;
    logic [OUT_CNT_W-1:0] res_removed_reg, res_count_reg;

    logic                 out_valid_reg;
    logic                 hit_reg, inserted_reg, table_full_reg;
    logic [OUT_CNT_W-1:0] removed_reg, count_reg;

    logic [ENTRIES-1:0]   act_vec;

    // ---------------- control FSM ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            GLT_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = GLT_BUSY;
                end
            end
            GLT_BUSY:
            begin
                if (tok_last.active)
                begin
                    state_next = GLT_DRAIN;
                end
            end
            GLT_DRAIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = GLT_IDLE;
                end
            end
            default:
            begin
                state_next = GLT_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        res_load = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            GLT_IDLE:
            begin
                in_stall = 1'b0;
            end
            GLT_BUSY:
            begin
                res_load = tok_last.active;
            end
            GLT_DRAIN:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
            end
        endcase
    end

    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= GLT_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- config and cycle tracking ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg    <= AGE_LIMIT_RESET;
            latest_cycle_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                age_limit_reg <= cfg_wdata;
            end
            // cycle start latches the new cycle number up front; the row
            // only reads it on cycle end and insert commit
            if (accept && (glt_op_t'(op) == OP_START))
            begin
                latest_cycle_reg <= cycle;
            end
        end
    end

    // ---------------- token injection ----------------
    always_comb
    begin
        tok_in_next            = '0;
        tok_in_next.active     = accept;
        tok_in_next.op         = glt_op_t'(op);
        tok_in_next.id         = graph_id;
        tok_in_next.cyc        = cycle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_in_reg <= '0;
        end
        else
        begin
            tok_in_reg <= tok_in_next;
        end
    end

    // ---------------- cell row ----------------
    assign chain[0] = tok_in_reg;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        glt_cell u_cell
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .idx          (IDX_W'(g)),
            .tok_in       (chain[g]),
            .wr           (wr),
            .latest_cycle (latest_cycle_reg),
            .age_limit    (age_limit_reg),
            .tok_out      (chain[g+1])
        );
        assign act_vec[g] = chain[g].active;
    end

    assign tok_last = chain[ENTRIES];

    // Insert commit: the whole row has been searched for a duplicate, so the
    // lowest free cell found on the way is written now.
    always_comb
    begin
        wr.en    = res_load && (tok_last.op == OP_INSERT) && !tok_last.found
                   && tok_last.free_found;
        wr.idx   = tok_last.free_idx;
        wr.key   = tok_last.id;
        wr.birth = latest_cycle_reg;
    end

    // ---------------- result stage ----------------
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_hit_reg     <= (tok_last.op == OP_CHECK) && tok_last.found;
            res_ins_reg     <= wr.en;
            res_full_reg    <= (tok_last.op == OP_INSERT) && !tok_last.found
                               && !tok_last.free_found;
            res_removed_reg <= OUT_CNT_W'(tok_last.removed);
            res_count_reg   <= OUT_CNT_W'(tok_last.count + CNT_W'(wr.en));
        end
    end

    // output register: holds a beat while the sink stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            hit_reg        <= res_hit_reg;
            inserted_reg   <= res_ins_reg;
            table_full_reg <= res_full_reg;
            removed_reg    <= res_removed_reg;
            count_reg      <= res_count_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign inserted      = inserted_reg;
    assign table_full    = table_full_reg;
    assign removed_count = removed_reg;
    assign entry_count   = count_reg;

    // ---------------- assertions ----------------
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({act_vec, tok_last.active}))
        else $error("more than one token in the cell row");

    a_exit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tok_last.active |-> state_reg == GLT_BUSY)
        else $error("token left the row outside BUSY");

    a_commit_unique: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> !tok_last.found && tok_last.op == OP_INSERT)
        else $error("insert commit for a duplicate key");

    a_ins_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(inserted_reg && table_full_reg))
        else $error("inserted and table_full both set");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for graph_id_lifetime_table: directed beats, then random cycle frames.
// Depends on glt_pkg, glt_cell and the graph_id_lifetime_table RTL; needs no other files.
module testbench import glt_pkg::*;
();

    // One result beat as the table reports it.
    typedef struct packed {
        logic                 hit;
        logic                 inserted;
        logic                 table_full;
        logic [OUT_CNT_W-1:0] removed_count;
        logic [OUT_CNT_W-1:0] entry_count;
    } table_result_t;

    // Shadow copy of the ID table. Each accepted input beat is run through it
    // and the outcome queued; result beats are checked in order against that queue.
    class lifetime_scoreboard;
        logic             live[ENTRIES];
        logic [ID_W-1:0]  key[ENTRIES];
        logic [1:0]       slot_code[ENTRIES][2];
        logic             seen[ENTRIES];
        logic [CYC_W-1:0] born[ENTRIES];
        logic [CYC_W-1:0] newest_cycle;
        logic [CYC_W-1:0] age_limit;
        table_result_t    pending_results[$];
        int               errors;
        int               beats;
        int               hits;
        int               new_entries;
        int               drops;
        int               evictions;

        function new();
            for (int i = 0; i < ENTRIES; i++)
            begin
                live[i] = 1'b0;
            end
            newest_cycle = '0;
            age_limit    = AGE_LIMIT_RESET;
            errors       = 0;
            beats        = 0;
            hits         = 0;
            new_entries  = 0;
            drops        = 0;
            evictions    = 0;
        endfunction

        function int lookup(logic [ID_W-1:0] id);
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (live[i] && key[i] == id)
                begin
                    return i;
                end
            end
            return -1;
        endfunction

        // Apply one accepted input beat and queue the result it must produce.
        function void note_beat(glt_op_t opc, logic [ID_W-1:0] id, logic [CYC_W-1:0] cyc);
            table_result_t    r;
            int               idx;
            int               used;
            logic [CYC_W-1:0] age;
            r = '0;
            beats++;
            case (opc)
                OP_INSERT:
                begin
                    if (lookup(id) < 0)
                    begin
                        idx = -1;
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (!live[i] && idx < 0)
                            begin
                                idx = i;
                            end
                        end
                        if (idx < 0)
                        begin
                            r.table_full = 1'b1;
                        end
                        else
                        begin
                            live[idx]         = 1'b1;
                            key[idx]          = id;
                            slot_code[idx][0] = ST_UNINIT;
                            slot_code[idx][1] = ST_UNINIT;
                            seen[idx]         = 1'b0;
                            born[idx]         = newest_cycle;
                            r.inserted        = 1'b1;
                        end
                    end
                end
                OP_START:
                begin
                    newest_cycle = cyc;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (live[i])
                        begin
                            slot_code[i][cyc[0]] = ST_CLEARED;
                        end
                    end
                end
                OP_CHECK:
                begin
                    idx = lookup(id);
                    if (idx >= 0)
                    begin
                        slot_code[idx][cyc[0]] = ST_SEEN;
                        seen[idx]              = 1'b1;
                        r.hit                  = 1'b1;
                    end
                end
                default:
                begin
                    used = 0;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (live[i] && slot_code[i][0] == ST_CLEARED &&
                            slot_code[i][1] == ST_CLEARED)
                        begin
                            age = newest_cycle - born[i];
                            if (seen[i] || age > age_limit)
                            begin
                                live[i] = 1'b0;
                                used++;
                            end
                        end
                    end
                    r.removed_count = used[OUT_CNT_W-1:0];
                end
            endcase
            used = 0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (live[i])
                begin
                    used++;
                end
            end
            r.entry_count = used[OUT_CNT_W-1:0];
            hits        += r.hit;
            new_entries += r.inserted;
            drops       += r.table_full;
            evictions   += r.removed_count;
            pending_results.push_back(r);
        endfunction

        // Compare one accepted result beat with the oldest queued outcome.
        function void check_result(table_result_t got);
            table_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("%t: unexpected result beat hit=%0b ins=%0b full=%0b rm=%0d cnt=%0d",
                             $realtime, got.hit, got.inserted, got.table_full,
                             got.removed_count, got.entry_count);
                end
                return;
            end
            want = pending_results.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("%t: result mismatch", $realtime);
                    $display("  expected hit=%0b ins=%0b full=%0b rm=%0d cnt=%0d",
                             want.hit, want.inserted, want.table_full,
                             want.removed_count, want.entry_count);
                    $display("  actual   hit=%0b ins=%0b full=%0b rm=%0d cnt=%0d",
                             got.hit, got.inserted, got.table_full,
                             got.removed_count, got.entry_count);
                end
            end
        endfunction
    endclass

    // Settle margin used before config writes and at the end.
    localparam int SETTLE    = ENTRIES + 8;
    localparam int POOL_SIZE = 40;   // more IDs than cells, so the table can fill up

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CYC_W-1:0]     cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           op = OP_INSERT;
    logic [ID_W-1:0]      graph_id = '0;
    logic [CYC_W-1:0]     cycle = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 hit;
    logic                 inserted;
    logic                 table_full;
    logic [OUT_CNT_W-1:0] removed_count;
    logic [OUT_CNT_W-1:0] entry_count;

    lifetime_scoreboard   sb;
    int                   burst_left = 0;
    int                   stall_left = 0;
    int                   stall_pick;
    int                   settings_used = 0;
    logic [CYC_W-1:0]     frame_cycle = '0;
    logic [ID_W-1:0]      id_pool[POOL_SIZE];

    always #5 clk = ~clk;

    graph_id_lifetime_table u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .graph_id       (graph_id),
        .cycle          (cycle),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .inserted       (inserted),
        .table_full     (table_full),
        .removed_count  (removed_count),
        .entry_count    (entry_count)
    );

    // Receiver back-pressure: long clear stretches, long stalls, and short random flicker.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_pick = $urandom_range(0, 9);
            if (stall_pick < 2)
            begin
                out_stall  <= 1'b0;
                stall_left = $urandom_range(50, 200);
            end
            else if (stall_pick < 5)
            begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(1, 40);
            end
            else
            begin
                out_stall  <= 1'($urandom_range(0, 1));
                stall_left = $urandom_range(0, 3);
            end
        end
        else
        begin
            stall_left--;
        end
    end

    // Monitor: values read here are the ones present at the edge, before any
    // update scheduled by it. Results are checked before the new beat is noted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                sb.check_result({hit, inserted, table_full, removed_count, entry_count});
            end
            if (in_valid && !in_stall)
            begin
                sb.note_beat(glt_op_t'(op), graph_id, cycle);
            end
        end
    end

    // Present one beat and hold it until accepted. A new burst opens with a
    // random gap; within a burst valid stays high from beat to beat.
    task automatic send_beat(input glt_op_t opc, input logic [ID_W-1:0] id,
                             input logic [CYC_W-1:0] cyc);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 45) : $urandom_range(0, 4);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        op       <= opc;
        graph_id <= id;
        cycle    <= cyc;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
    endtask

    // Stop sending and wait until every queued outcome has been matched.
    task automatic drain_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (sb.pending_results.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Only called with the block idle.
    task automatic write_age_limit(input logic [CYC_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.age_limit = value;
        settings_used++;
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 7) == 0)
        begin
            return $urandom;
        end
        return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Random traffic. Most of it is well-formed frames (start, inserts, checks
    // on the frame's cycle, end); the rest is noise and frames with no end.
    task automatic run_traffic(input int n_beats, input bit insert_heavy);
        int sent;
        int n_ins;
        int n_chk;
        sent = 0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            id_pool[i] = $urandom;
        end
        id_pool[0] = '0;
        id_pool[1] = '1;
        id_pool[2] = 32'h8000_0000;
        while (sent < n_beats)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                send_beat(glt_op_t'($urandom_range(0, 3)), pick_id(), $urandom);
                sent++;
            end
            else
            begin
                // mostly consecutive cycle numbers, now and then a jump (wraps too)
                frame_cycle += ($urandom_range(0, 15) == 0) ? $urandom : 32'd1;
                send_beat(OP_START, $urandom, frame_cycle);
                n_ins = insert_heavy ? $urandom_range(1, 6) : $urandom_range(0, 3);
                n_chk = $urandom_range(0, 4);
                for (int k = 0; k < n_ins; k++)
                begin
                    send_beat(OP_INSERT, pick_id(), $urandom);
                end
                for (int k = 0; k < n_chk; k++)
                begin
                    // a check on the other slot now and then
                    send_beat(OP_CHECK, pick_id(),
                              frame_cycle + (($urandom_range(0, 5) == 0) ? 32'd1 : 32'd0));
                end
                sent += 1 + n_ins + n_chk;
                if ($urandom_range(0, 7) != 0)
                begin
                    send_beat(OP_END, $urandom, $urandom);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the age limit still at its reset value.
        send_beat(OP_CHECK,  32'h0000_0000, 32'h0000_0000);  // miss on empty table
        send_beat(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_beat(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_beat(OP_INSERT, 32'h0000_0000, 32'h0000_0000);  // duplicate, no change
        send_beat(OP_START,  32'h0000_0000, 32'h0000_0000);
        send_beat(OP_CHECK,  32'hFFFF_FFFF, 32'h0000_0000);  // hit, marks seen
        send_beat(OP_END,    32'h0000_0000, 32'h0000_0000);  // slot 1 still uninitialized
        send_beat(OP_START,  32'h0000_0000, 32'h0000_0001);
        send_beat(OP_END,    32'h0000_0000, 32'h0000_0000);  // young unseen entry stays
        send_beat(OP_START,  32'h0000_0000, 32'hFFFF_FFFE);
        send_beat(OP_END,    32'hFFFF_FFFF, 32'hFFFF_FFFF);  // both go: one old, one seen
        send_beat(OP_INSERT, 32'h1234_5678, 32'h0000_0000);  // born near the top of the range
        send_beat(OP_START,  32'h0000_0000, 32'hFFFF_FFFF);
        send_beat(OP_START,  32'h0000_0000, 32'h0000_0002);  // wraps; age is only 4
        send_beat(OP_END,    32'h0000_0000, 32'h0000_0000);
        send_beat(OP_CHECK,  32'hA5A5_A5A5, 32'hFFFF_FFFF);  // miss
        send_beat(OP_CHECK,  32'h1234_5678, 32'hFFFF_FFFF);  // hit on slot 1
        send_beat(OP_END,    32'h0000_0000, 32'h0000_0000);
        drain_results();

        // Random part, one phase per age limit, extremes included.
        write_age_limit(32'd0);
        run_traffic(200, 1'b0);
        drain_results();
        write_age_limit(32'd3);
        run_traffic(200, 1'b0);
        drain_results();
        write_age_limit(32'hFFFF_FFFF);  // only seen entries leave: table fills
        run_traffic(200, 1'b1);
        drain_results();
        write_age_limit(AGE_LIMIT_RESET);
        run_traffic(200, 1'b1);
        drain_results();
        write_age_limit($urandom);
        run_traffic(200, 1'b0);
        drain_results();

        $display("Ran %0d beats over %0d age-limit settings: %0d hits, %0d new entries,",
                 sb.beats, settings_used + 1, sb.hits, sb.new_entries);
        $display("%0d inserts dropped on a full table, %0d evictions, %0d errors.",
                 sb.drops, sb.evictions, sb.errors);
        if (sb.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: a correct run needs well under a fifth of this.
    initial
    begin
        #10ms;
        $display("Timed out with %0d results still expected.", sb.pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
sv/glt_pkg.sv
sv/glt_cell.sv
sv/graph_id_lifetime_table.sv
bench/testbench.sv
